### rtl/core/wma_pkg.sv
// Shared types and constants for the windowed moving average block.
package wma_pkg;

    // Width and reset value of the window length register
    localparam int unsigned LEN_W = 9;
    localparam logic [LEN_W-1:0] LEN_RESET = 9'd1;

    // Item sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ACC  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } wma_state_t;

endpackage

### rtl/core/wma_hist_mem.sv
// Sample history memory: one write port, one registered read port.
module wma_hist_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/wma_divider.sv
// Signed by unsigned restoring divider, one quotient bit per cycle, truncating toward zero.
module wma_divider #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 9
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0]        divisor,
    output logic                    done,
    output logic [NUM_W-1:0]        quotient
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;

    logic [NUM_W-1:0] mag;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   rem_step;
    logic             ge;

    always_comb
    begin
        mag      = dividend[NUM_W-1] ? -dividend : dividend;
        trial    = {rem_reg, quot_reg[NUM_W-1]};
        ge       = (trial >= {1'b0, den_reg});
        rem_step = ge ? (trial - {1'b0, den_reg}) : trial;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NUM_W);
            quot_next = mag;
            rem_next  = '0;
            den_next  = divisor;
            neg_next  = dividend[NUM_W-1];
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[NUM_W-2:0], ge};
            rem_next  = rem_step[DEN_W-1:0];
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -quot_reg : quot_reg;

endmodule

### rtl/core/windowed_moving_average_top.sv
// Windowed moving average: history memory, running sum and iterative divider.
// Each accepted word passes the accumulate, divide and output states; its result is then registered.
// A new word is not taken until the previous word's quotient has been loaded into the output register.
// A new word is taken while the previous result still waits in the output register.
// Reset clears the running sum, fill count and write position and sets the window to 1.
// The history memory is not cleared; only entries written since the last restart are read.
module windowed_moving_average_top #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          window_length_we,
    input  logic [wma_pkg::LEN_W-1:0]     window_length,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] average
);

    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + ADDR_W;
    localparam int PW     = CNT_W + 1;

    wma_pkg::wma_state_t state_reg, state_next;

    logic [CNT_W-1:0]       eff_len_reg, eff_len_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [ADDR_W-1:0]      pos_reg, pos_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] average_reg, average_next;

    logic                   in_accept;
    logic                   full;
    logic [CNT_W-1:0]       cfg_len;
    logic [PW-1:0]          leave_direct;
    logic [PW-1:0]          leave_wrap;
    logic [ADDR_W-1:0]      leave_addr;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SUM_W-1:0]       old_ext;
    logic [SUM_W-1:0]       new_ext;
    logic                   acc_step;
    logic                   div_done;
    logic [SUM_W-1:0]       quotient;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != wma_pkg::ST_IDLE);
    assign full      = (fill_reg >= eff_len_reg);
    assign acc_step  = (state_reg == wma_pkg::ST_ACC);

    // Zero length means one; lengths above the memory depth saturate
    always_comb
    begin
        if (window_length == '0)
        begin
            cfg_len = CNT_W'(1);
        end
        else if (32'(window_length) > 32'(MAX_WINDOW))
        begin
            cfg_len = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            cfg_len = CNT_W'(window_length);
        end
    end

    // Slot of the sample leaving the window, modulo the memory depth
    always_comb
    begin
        leave_direct = PW'(pos_reg) - PW'(eff_len_reg);
        leave_wrap   = PW'(pos_reg) + PW'(MAX_WINDOW) - PW'(eff_len_reg);
        if (PW'(pos_reg) >= PW'(eff_len_reg))
        begin
            leave_addr = leave_direct[ADDR_W-1:0];
        end
        else
        begin
            leave_addr = leave_wrap[ADDR_W-1:0];
        end
    end

    assign old_ext = {{ADDR_W{rd_data[SAMPLE_BITS-1]}}, rd_data};
    assign new_ext = {{ADDR_W{sample_reg[SAMPLE_BITS-1]}}, sample_reg};

    always_comb
    begin
        state_next     = state_reg;
        eff_len_next   = eff_len_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        average_next   = average_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            wma_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = wma_pkg::ST_ACC;
                end
            end
            wma_pkg::ST_ACC:
            begin
                if (full)
                begin
                    sum_next  = sum_reg - signed'(old_ext) + signed'(new_ext);
                    fill_next = eff_len_reg;
                end
                else
                begin
                    sum_next  = sum_reg + signed'(new_ext);
                    fill_next = fill_reg + CNT_W'(1);
                end
                if (pos_reg == ADDR_W'(MAX_WINDOW - 1))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + ADDR_W'(1);
                end
                state_next = wma_pkg::ST_DIV;
            end
            wma_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = wma_pkg::ST_OUT;
                end
            end
            wma_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    average_next   = quotient[SAMPLE_BITS-1:0];
                    state_next     = wma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wma_pkg::ST_IDLE;
            end
        endcase

        // Restart averaging on a length write
        if (window_length_we)
        begin
            eff_len_next = cfg_len;
            fill_next    = '0;
            pos_next     = '0;
            sum_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wma_pkg::ST_IDLE;
            eff_len_reg   <= CNT_W'(wma_pkg::LEN_RESET);
            fill_reg      <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            eff_len_reg   <= eff_len_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample;
        end
        average_reg <= average_next;
    end

    wma_hist_mem #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_BITS)
    ) u_hist (
        .clk     (clk),
        .wr_en   (acc_step),
        .wr_addr (pos_reg),
        .wr_data (sample_reg),
        .rd_en   (in_accept),
        .rd_addr (leave_addr),
        .rd_data (rd_data)
    );

    wma_divider #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (acc_step),
        .dividend (sum_next),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_valid = out_valid_reg;
    assign average   = average_reg;

    a_accept_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == wma_pkg::ST_ACC))
        else $error("accepted word did not move to accumulate");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= eff_len_reg) && (eff_len_reg != '0))
        else $error("fill count exceeds window length");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == wma_pkg::ST_DIV))
        else $error("divider finished outside divide state");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == wma_pkg::ST_OUT))
        else $error("output loaded without a finished quotient");

endmodule

### tb/windowed_moving_average_top_tb.sv
// Self-checking testbench for the windowed moving average block.
`timescale 1ns / 1ps

module windowed_moving_average_top_tb;

    localparam int MAX_WIN     = 256;
    localparam int SMP_W       = 16;
    localparam int LATENCY     = 27;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DIR_N       = 25;
    localparam int PHASE_N     = 10;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WINDOW
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [SMP_W-1:0] value;
        logic             has_avg;
        logic [SMP_W-1:0] avg;
    } dir_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           window_length_we = 1'b0;
    logic [wma_pkg::LEN_W-1:0]      window_length = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic signed [SMP_W-1:0]        sample = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic signed [SMP_W-1:0]        average;

    // expected averages, oldest first
    logic signed [SMP_W-1:0]        avg_expected_q [$];
    int                             fail_cnt = 0;
    int                             cycle_cnt = 0;
    int                             stall_cnt = 0;

    // shadow of the block state
    logic signed [SMP_W-1:0]        hist_mem [MAX_WIN];
    logic [wma_pkg::LEN_W-1:0]      win_reg = wma_pkg::LEN_RESET;
    int                             run_sum = 0;
    int unsigned                    fill_cnt = 0;
    int unsigned                    wr_pos = 0;

    // window 1 after reset: the average is the sample itself
    dir_row_t dir_tab [DIR_N] = '{
        '{ROW_SAMPLE, 16'h7fff, 1'b1, 16'h7fff},
        '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h8000},
        '{ROW_SAMPLE, 16'h0000, 1'b1, 16'h0000},
        '{ROW_SAMPLE, 16'hffff, 1'b1, 16'hffff},
        '{ROW_WINDOW, 16'd0,    1'b0, 16'h0000},   // zero length acts as 1
        '{ROW_SAMPLE, 16'h1234, 1'b1, 16'h1234},
        '{ROW_SAMPLE, 16'hedcc, 1'b1, 16'hedcc},
        '{ROW_WINDOW, 16'd2,    1'b0, 16'h0000},
        '{ROW_SAMPLE, 16'h0003, 1'b1, 16'h0003},
        '{ROW_SAMPLE, 16'h0004, 1'b1, 16'h0003},
        '{ROW_SAMPLE, 16'hfff9, 1'b1, 16'hffff},   // -3/2 truncates to -1
        '{ROW_SAMPLE, 16'h8000, 1'b1, 16'hbffd},
        '{ROW_WINDOW, 16'd3,    1'b0, 16'h0000},
        '{ROW_SAMPLE, 16'h7fff, 1'b1, 16'h7fff},
        '{ROW_SAMPLE, 16'h7fff, 1'b1, 16'h7fff},
        '{ROW_SAMPLE, 16'h7fff, 1'b1, 16'h7fff},
        '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h2aaa},
        '{ROW_WINDOW, 16'd511,  1'b0, 16'h0000},   // saturates to the max window
        '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h8000},
        '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h8000},
        '{ROW_SAMPLE, 16'h0100, 1'b0, 16'h0000},
        '{ROW_SAMPLE, 16'hffff, 1'b0, 16'h0000},
        '{ROW_WINDOW, 16'd256,  1'b0, 16'h0000},
        '{ROW_SAMPLE, 16'h7fff, 1'b1, 16'h7fff},
        '{ROW_SAMPLE, 16'h0001, 1'b0, 16'h0000}
    };

    windowed_moving_average_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .window_length_we (window_length_we),
        .window_length    (window_length),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .average          (average)
    );

    always #5 clk = ~clk;

    function automatic int unsigned eff_window(input logic [wma_pkg::LEN_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > MAX_WIN)
            return MAX_WIN;
        return 32'(len);
    endfunction

    // advance the shadow state by one sample, return the new average
    function automatic logic signed [SMP_W-1:0] avg_predict(input logic signed [SMP_W-1:0] x);
        int unsigned len;
        int unsigned leave_pos;
        int          quot;
        len = eff_window(win_reg);
        if (fill_cnt >= len)
        begin
            leave_pos = (wr_pos + MAX_WIN - len) % MAX_WIN;
            run_sum   = run_sum - hist_mem[leave_pos];
            fill_cnt  = len;
        end
        else
            fill_cnt = fill_cnt + 1;
        run_sum          = run_sum + x;
        hist_mem[wr_pos] = x;
        wr_pos           = (wr_pos + 1) % MAX_WIN;
        quot             = run_sum / int'(fill_cnt);
        return quot[SMP_W-1:0];
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return SMP_W'($urandom());
        endcase
    endfunction

    // called at a rising edge; returns at the edge that accepted the word
    task automatic drive_word(input logic signed [SMP_W-1:0] x, input int gap,
                              input logic has_avg, input logic signed [SMP_W-1:0] avg);
        logic signed [SMP_W-1:0] pred;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= x;
        do
            @(posedge clk);
        while (in_stall);
        pred = avg_predict(x);
        avg_expected_q = {avg_expected_q, (has_avg ? avg : pred)};
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (avg_expected_q.size() != 0)
            @(posedge clk);
    endtask

    // register write only with the block idle; restarts averaging
    task automatic write_window(input logic [wma_pkg::LEN_W-1:0] len);
        wait_drained();
        window_length_we <= 1'b1;
        window_length    <= len;
        @(posedge clk);
        window_length_we <= 1'b0;
        window_length    <= 9'($urandom());
        win_reg  = len;
        run_sum  = 0;
        fill_cnt = 0;
        wr_pos   = 0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (avg_expected_q.size() == 0)
            begin
                $error("average: unexpected word, actual %0d", average);
                fail_cnt++;
            end
            else
            begin
                if (average !== avg_expected_q[0])
                begin
                    $error("average mismatch: expected %0d, actual %0d",
                           avg_expected_q[0], average);
                    fail_cnt++;
                end
                void'(avg_expected_q.pop_front());
            end
        end
    end

    // output back-pressure: short and long stalls, with free-running stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_cnt <= 0;
        end
        else if (stall_cnt != 0)
            stall_cnt <= stall_cnt - 1;
        else if (out_stall)
        begin
            out_stall <= 1'b0;
            stall_cnt <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                      : $urandom_range(0, 6);
        end
        else
        begin
            out_stall <= 1'b1;
            stall_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [wma_pkg::LEN_W-1:0] win;
        int                        n_words;
        bit                        no_gaps;
        for (int i = 0; i < MAX_WIN; i++)
            hist_mem[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            if (dir_tab[i].kind == ROW_WINDOW)
                write_window(dir_tab[i].value[wma_pkg::LEN_W-1:0]);
            else
                drive_word(dir_tab[i].value, gap_len(), dir_tab[i].has_avg, dir_tab[i].avg);
        end

        for (int ph = 0; ph < PHASE_N; ph++)
        begin
            case (ph)
                0: win = 9'd256;
                1: win = 9'd1;
                2: win = 9'd2;
                3: win = 9'd511;
                4: win = 9'd0;
                5: win = 9'd255;
                6: win = 9'($urandom_range(3, 32));
                7: win = 9'($urandom_range(0, 511));
                8: win = 9'($urandom_range(1, 8));
                default: win = 9'd128;
            endcase
            write_window(win);
            if (eff_window(win) >= 200)
                n_words = eff_window(win) + $urandom_range(40, 60);
            else
                n_words = $urandom_range(30, 80);
            no_gaps = (ph % 3 == 2);
            for (int k = 0; k < n_words; k++)
            begin
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
                drive_word(rand_sample(), no_gaps ? 0 : gap_len(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
